[rtl/core/hhbp_pkg.sv]
// ----------------------------------------------------------------------------
// hhbp_pkg
// Shared types and constants of the header block parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hhbp_pkg;

	// width of the value offset limit register
	localparam int CFG_BITS = 12;

	// event codes reported per byte
	localparam logic [2:0] EV_PROGRESS = 3'd0;
	localparam logic [2:0] EV_FIELD    = 3'd1;
	localparam logic [2:0] EV_BLOCK    = 3'd2;
	localparam logic [2:0] EV_ERROR    = 3'd3;
	localparam logic [2:0] EV_BODY     = 3'd4;

	// reset value of the value offset limit
	localparam logic [CFG_BITS-1:0] MAX_OFFSET_RST = 12'd255;

	// special characters
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// one input beat as held in the input register
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} step_t;

endpackage

`default_nettype wire

[rtl/core/hhbp_fsm.sv]
// ----------------------------------------------------------------------------
// hhbp_fsm
// Parse state machine with key/value counters; one byte per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hhbp_fsm #(
	parameter int LENGTH_BITS = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            en,
	input  wire hhbp_pkg::step_t           step,
	input  wire [hhbp_pkg::CFG_BITS-1:0]   max_off,
	output logic [2:0]                     ev,
	output logic [LENGTH_BITS-1:0]         klen,
	output logic [LENGTH_BITS-1:0]         vlen
);

	localparam logic [3:0] PH_SKIP   = 4'd0;
	localparam logic [3:0] PH_KEY    = 4'd1;
	localparam logic [3:0] PH_COLON  = 4'd2;
	localparam logic [3:0] PH_SPACE  = 4'd3;
	localparam logic [3:0] PH_VALUE  = 4'd4;
	localparam logic [3:0] PH_CR     = 4'd5;
	localparam logic [3:0] PH_LF     = 4'd6;
	localparam logic [3:0] PH_END_CR = 4'd7;
	localparam logic [3:0] PH_END_LF = 4'd8;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam int CMP_W = (LENGTH_BITS > hhbp_pkg::CFG_BITS) ? LENGTH_BITS
		: hhbp_pkg::CFG_BITS;

	logic [3:0]             phase_q, phase_c, phase_n;
	logic [LENGTH_BITS-1:0] key_q, key_c, key_n;
	logic [LENGTH_BITS-1:0] val_q, val_c, val_n;
	logic                   err_q, err_c, err_n;
	logic                   fail;
	logic                   is_crlf;
	logic                   over_limit;
	logic [7:0]             b;

	assign b       = step.data_byte;
	assign is_crlf = (b == hhbp_pkg::CH_CR) || (b == hhbp_pkg::CH_LF);
	assign over_limit = CMP_W'(val_c) > CMP_W'(max_off);

	always_comb begin
		// restart clears everything before the byte is handled
		phase_c = step.restart ? PH_SKIP : phase_q;
		key_c   = step.restart ? '0 : key_q;
		val_c   = step.restart ? '0 : val_q;
		err_c   = step.restart ? 1'b0 : err_q;

		phase_n = phase_c;
		key_n   = key_c;
		val_n   = val_c;
		err_n   = err_c;
		fail    = 1'b0;
		ev      = hhbp_pkg::EV_PROGRESS;
		klen    = '0;
		vlen    = '0;

		if (err_c) begin
			ev = hhbp_pkg::EV_ERROR;
		end else begin
			unique case (phase_c)
				PH_SKIP: begin
					if (!is_crlf) begin
						key_n   = LEN_ONE;
						phase_n = PH_KEY;
					end
				end
				PH_KEY: begin
					priority if (b == hhbp_pkg::CH_COLON) begin
						if (key_c == '0) fail = 1'b1;
						else phase_n = PH_COLON;
					end else if (is_crlf) begin
						fail = 1'b1;
					end else begin
						key_n = (key_c == LEN_MAX) ? key_c : key_c + LEN_ONE;
					end
				end
				PH_COLON: begin
					if (b == hhbp_pkg::CH_SPACE) phase_n = PH_SPACE;
					else fail = 1'b1;
				end
				PH_SPACE: begin
					priority if (b == hhbp_pkg::CH_CR) begin
						fail = 1'b1;
					end else if (b == hhbp_pkg::CH_LF) begin
						val_n   = '0;
						phase_n = PH_VALUE;
					end else begin
						val_n   = LEN_ONE;
						phase_n = PH_VALUE;
					end
				end
				PH_VALUE: begin
					priority if (b == hhbp_pkg::CH_CR) begin
						if (val_c == '0) fail = 1'b1;
						else phase_n = PH_CR;
					end else if (over_limit) begin
						fail = 1'b1;
					end else begin
						val_n = (val_c == LEN_MAX) ? val_c : val_c + LEN_ONE;
					end
				end
				PH_CR: begin
					if (b == hhbp_pkg::CH_LF) begin
						phase_n = PH_LF;
						ev      = hhbp_pkg::EV_FIELD;
						klen    = key_c;
						vlen    = val_c;
					end else begin
						fail = 1'b1;
					end
				end
				PH_LF: begin
					if (b == hhbp_pkg::CH_CR) begin
						phase_n = PH_END_CR;
					end else begin
						key_n   = LEN_ONE;
						phase_n = PH_KEY;
					end
				end
				PH_END_CR: begin
					if (b == hhbp_pkg::CH_LF) begin
						phase_n = PH_END_LF;
						ev      = hhbp_pkg::EV_BLOCK;
					end else begin
						fail = 1'b1;
					end
				end
				PH_END_LF: ev = hhbp_pkg::EV_BODY;
				default: fail = 1'b1;
			endcase
			if (fail) begin
				err_n = 1'b1;
				ev    = hhbp_pkg::EV_ERROR;
				klen  = '0;
				vlen  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			key_q   <= '0;
			val_q   <= '0;
			err_q   <= 1'b0;
		end else if (en) begin
			phase_q <= phase_n;
			key_q   <= key_n;
			val_q   <= val_n;
			err_q   <= err_n;
		end
	end

endmodule

`default_nettype wire

[rtl/core/http_header_block_parser.sv]
// ----------------------------------------------------------------------------
// http_header_block_parser
// Byte-stream checker for an HTTP header block, one event per byte.
// ----------------------------------------------------------------------------
// Feed the raw header bytes one beat each on the s_ side; every beat yields
// exactly one result beat on the m_ side: progress, field complete (with key
// and value lengths), block complete, error, or body byte once the blank line
// has closed the block. An error sticks until a beat arrives with restart set,
// which also starts a new block with that byte. The block takes one beat per
// clock with no bubbles while m_tready does not stall it; a taken byte passes
// one input register, then the result register, before its result shows on
// the m_ side, and the parse state is the only loop. Once both registers
// hold a beat, backpressure on m_tready stalls the input side in the same
// cycle. cfg_data sets the largest allowed offset of a value byte from the
// first value byte; write it only while the block is idle. Key and value
// lengths saturate at 2^LENGTH_BITS - 1.
// ----------------------------------------------------------------------------
`default_nettype none

module http_header_block_parser #(
	parameter int LENGTH_BITS = 12
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	// input beats
	input  wire                                       s_tvalid,
	output logic                                      s_tready,
	input  wire  [7:0]                                s_tdata,  // [7:0] data_byte
	input  wire  [0:0]                                s_tuser,  // [0] restart
	// result beats
	output logic                                      m_tvalid,
	input  wire                                       m_tready,
	// from bit 0: key_length, value_length, zero pad to whole bytes
	output logic [((2*LENGTH_BITS+7)/8)*8-1:0]        m_tdata,
	output logic [2:0]                                m_tuser,  // [2:0] event_res
	// value offset limit
	input  wire                                       cfg_valid,
	output logic                                      cfg_ready,
	input  wire  [hhbp_pkg::CFG_BITS-1:0]             cfg_data
);

	localparam int TDATA_W = ((2*LENGTH_BITS+7)/8)*8;

	logic                            valid_s1;
	hhbp_pkg::step_t                 step_s1;
	logic                            valid_s2;
	logic [2:0]                      event_s2;
	logic [LENGTH_BITS-1:0]          klen_s2;
	logic [LENGTH_BITS-1:0]          vlen_s2;
	logic [hhbp_pkg::CFG_BITS-1:0]   max_off_q;

	logic                            advance;
	logic [2:0]                      ev;
	logic [LENGTH_BITS-1:0]          klen;
	logic [LENGTH_BITS-1:0]          vlen;

	// byte in s1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_off_q <= hhbp_pkg::MAX_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_off_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			step_s1.data_byte <= s_tdata;
			step_s1.restart   <= s_tuser[0];
		end
	end

	// parse state advances together with the byte leaving s1
	hhbp_fsm #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.step    (step_s1),
		.max_off (max_off_q),
		.ev      (ev),
		.klen    (klen),
		.vlen    (vlen)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= ev;
			klen_s2  <= klen;
			vlen_s2  <= vlen;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = event_s2;
	assign m_tdata  = TDATA_W'({vlen_s2, klen_s2});

endmodule

`default_nettype wire

[rtl/core/hhbp_chk.sv]
// ----------------------------------------------------------------------------
// hhbp_chk
// Port-level checks of the header block parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hhbp_chk #(
	parameter int LENGTH_BITS = 12
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 m_tvalid,
	input wire                                 m_tready,
	input wire [((2*LENGTH_BITS+7)/8)*8-1:0]   m_tdata,
	input wire [2:0]                           m_tuser
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// lengths only travel with a field event
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != hhbp_pkg::EV_FIELD) |-> (m_tdata == '0))
		else $error("nonzero lengths on a non-field event");

	// a completed field has a key and a value
	a_field_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == hhbp_pkg::EV_FIELD) |->
		(m_tdata[LENGTH_BITS-1:0] != '0) && (m_tdata[2*LENGTH_BITS-1:LENGTH_BITS] != '0))
		else $error("field event with an empty key or value");

	// event code in range
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == hhbp_pkg::EV_PROGRESS) || (m_tuser == hhbp_pkg::EV_FIELD)
		|| (m_tuser == hhbp_pkg::EV_BLOCK) || (m_tuser == hhbp_pkg::EV_ERROR)
		|| (m_tuser == hhbp_pkg::EV_BODY))
		else $error("undefined event code");

endmodule

bind http_header_block_parser hhbp_chk #(
	.LENGTH_BITS(LENGTH_BITS)
) u_hhbp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
